// ===== rtl/ptc_pkg.sv =====
// Shared types and constants of the pressure/temperature/humidity compensation block.
package ptc_pkg;

   localparam int RAW_W    = 24;   // raw conversion fields on the request channel
   localparam int HRAW_W   = 16;   // raw humidity word
   localparam int COEF_W   = 16;   // calibration coefficient width
   localparam int CSR_IDX_W = 3;

   localparam int DT_W     = 25;   // D2 - C5*2^8
   localparam int MUL_W    = 41;   // dT times one coefficient
   localparam int OFF_W    = 36;
   localparam int SENS_W   = 35;
   localparam int SLO_W    = 17;   // low, unsigned slice of SENS for the split multiply
   localparam int SHI_W    = SENS_W - SLO_W;

   localparam int TEMP_W   = 18;
   localparam int PRES_W   = 21;
   localparam int HUM_W    = 15;
   localparam int HCOMP_W  = 16;
   localparam int DEG_W    = 12;

   localparam int TEMP_BASE    = 2000;
   localparam int DEG_DIV      = 100;
   localparam int DEG_SH       = 25;
   localparam int DEG_RECIP    = ((1 << DEG_SH) + DEG_DIV - 1) / DEG_DIV;
   localparam int DEG_PROD_W   = 36;
   localparam int HUM_SCALE    = 12500;
   localparam int HUM_OFFSET   = -600;
   localparam int HUM_SLOPE    = 18;
   localparam int HUM_REF_DEG  = 20;
   localparam int HUM_PROD_W   = 30;

   localparam int TEMP_MAX  = 2 ** (TEMP_W - 1) - 1;
   localparam int TEMP_MIN  = -(2 ** (TEMP_W - 1));
   localparam int PRES_MAX  = 2 ** (PRES_W - 1) - 1;
   localparam int PRES_MIN  = -(2 ** (PRES_W - 1));
   localparam int HCOMP_MAX = 2 ** (HCOMP_W - 1) - 1;
   localparam int HCOMP_MIN = -(2 ** (HCOMP_W - 1));

   localparam int STAGES = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_C1 = 3'd0,
      REG_C2 = 3'd1,
      REG_C3 = 3'd2,
      REG_C4 = 3'd3,
      REG_C5 = 3'd4,
      REG_C6 = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
   } coef_type;

   typedef struct packed {
      logic [STAGES-1:0] load;   // stage k takes the beat from stage k-1
   } pipe_ctl_type;

   // dT (signed) times an unsigned coefficient, exact in MUL_W bits
   function automatic logic signed [MUL_W-1:0] mul_dt(input logic signed [DT_W-1:0] dt,
                                                      input logic [COEF_W-1:0] c);
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
      a = {{(MUL_W-DT_W){dt[DT_W-1]}}, dt};
      b = $signed({{(MUL_W-COEF_W){1'b0}}, c});
      return a * b;
   endfunction

endpackage

// ===== rtl/ptc_if.sv =====
// Valid/ready channel interfaces for raw sensor beats and compensated result beats.
interface ptc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ptc_pkg::RAW_W-1:0]   pressure_raw;
   logic [ptc_pkg::RAW_W-1:0]   temperature_raw;
   logic [ptc_pkg::HRAW_W-1:0]  humidity_raw;

   modport source (output valid, output pressure_raw, output temperature_raw,
                   output humidity_raw, input ready);
   modport sink   (input valid, input pressure_raw, input temperature_raw,
                   input humidity_raw, output ready);
endinterface

interface ptc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centi;
   logic signed [ptc_pkg::PRES_W-1:0]  pressure_centi_mbar;
   logic signed [ptc_pkg::HUM_W-1:0]   humidity_plain_centi;
   logic signed [ptc_pkg::HCOMP_W-1:0] humidity_comp_centi;

   modport source (output valid, output temperature_centi, output pressure_centi_mbar,
                   output humidity_plain_centi, output humidity_comp_centi, input ready);
   modport sink   (input valid, input temperature_centi, input pressure_centi_mbar,
                   input humidity_plain_centi, input humidity_comp_centi, output ready);
endinterface

// ===== rtl/ptc_csr.sv =====
// Calibration coefficient registers with a plain indexed write port.
module ptc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]      csr_wdata,
   output ptc_pkg::coef_type               coef
);

   ptc_pkg::coef_type coef_ff;
   ptc_pkg::coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (ptc_pkg::reg_index_type'(csr_index))
            ptc_pkg::REG_C1: coef_in.c1 = csr_wdata;
            ptc_pkg::REG_C2: coef_in.c2 = csr_wdata;
            ptc_pkg::REG_C3: coef_in.c3 = csr_wdata;
            ptc_pkg::REG_C4: coef_in.c4 = csr_wdata;
            ptc_pkg::REG_C5: coef_in.c5 = csr_wdata;
            ptc_pkg::REG_C6: coef_in.c6 = csr_wdata;
            default: ;   // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== rtl/ptc_pipe_ctrl.sv =====
// Per-stage occupancy bits and load enables; bubbles close up under back-pressure.
module ptc_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ptc_pkg::pipe_ctl_type ctl
);

   localparam int N = ptc_pkg::STAGES;

   logic [N-1:0] full_ff;
   logic [N-1:0] full_in;
   logic [N-1:0] load;

   // a stage loads when it is empty or its beat moves on this cycle
   always_comb begin
      load[N-1] = ~full_ff[N-1] | out_ready;
      for (int k = N - 2; k >= 0; k--) begin
         load[k] = ~full_ff[k] | load[k+1];
      end
   end

   always_comb begin
      full_in = full_ff;
      if (load[0]) begin
         full_in[0] = in_valid;
      end
      for (int k = 1; k < N; k++) begin
         if (load[k]) begin
            full_in[k] = full_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else begin
         full_ff <= full_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = full_ff[N-1];
   assign ctl.load  = load;

endmodule

// ===== rtl/ptc_datapath.sv =====
// Six-stage compensation datapath: dT, coefficient products, OFF/SENS/TEMP,
// split D1*SENS multiply, recombine, pressure and humidity outputs.
module ptc_datapath #(
   parameter int ADC_BITS = 24
) (
   input  logic                                 clock,
   input  ptc_pkg::pipe_ctl_type                ctl,
   input  ptc_pkg::coef_type                    coef,
   input  logic [ptc_pkg::RAW_W-1:0]            pressure_raw,
   input  logic [ptc_pkg::RAW_W-1:0]            temperature_raw,
   input  logic [ptc_pkg::HRAW_W-1:0]           humidity_raw,
   output logic signed [ptc_pkg::TEMP_W-1:0]    temperature_centi,
   output logic signed [ptc_pkg::PRES_W-1:0]    pressure_centi_mbar,
   output logic signed [ptc_pkg::HUM_W-1:0]     humidity_plain_centi,
   output logic signed [ptc_pkg::HCOMP_W-1:0]   humidity_comp_centi
);

   localparam int DT_W   = ptc_pkg::DT_W;
   localparam int MUL_W  = ptc_pkg::MUL_W;
   localparam int OFF_W  = ptc_pkg::OFF_W;
   localparam int SENS_W = ptc_pkg::SENS_W;
   localparam int SLO_W  = ptc_pkg::SLO_W;
   localparam int SHI_W  = ptc_pkg::SHI_W;
   localparam int TEMP_W = ptc_pkg::TEMP_W;
   localparam int PRES_W = ptc_pkg::PRES_W;
   localparam int HUM_W  = ptc_pkg::HUM_W;
   localparam int HC_W   = ptc_pkg::HCOMP_W;
   localparam int DEG_W  = ptc_pkg::DEG_W;
   localparam int QP_W   = ptc_pkg::DEG_PROD_W;
   localparam int HP_W   = ptc_pkg::HUM_PROD_W;
   localparam int COEF_W = ptc_pkg::COEF_W;

   localparam int PLO_W  = ADC_BITS + SLO_W;          // D1 * SENS[16:0]
   localparam int PHI_W  = ADC_BITS + SHI_W + 1;      // D1 * SENS[34:17], signed
   localparam int FULL_W = PHI_W + SLO_W;             // recombined D1*SENS
   localparam int PS_W   = ADC_BITS + 15;             // D1*SENS / 2^21
   localparam int DIFF_W = ((PS_W > OFF_W) ? PS_W : OFF_W) + 1;
   localparam int TSUM_W = TEMP_W + 1;
   localparam int ADJ_W  = 18;
   localparam int D20_W  = DEG_W + 1;

   // ---------------- stage 1: dT and plain humidity
   logic signed [DT_W-1:0]   s1_dt_ff,     s1_dt_in;
   logic [ADC_BITS-1:0]      s1_d1_ff,     s1_d1_in;
   logic signed [HUM_W-1:0]  s1_hum_ff,    s1_hum_in;
   logic [HP_W-1:0]          hum_prod;

   assign s1_d1_in = pressure_raw[ADC_BITS-1:0];
   assign s1_dt_in = $signed({{(DT_W-ADC_BITS){1'b0}}, temperature_raw[ADC_BITS-1:0]})
                   - $signed({1'b0, coef.c5, 8'h00});
   assign hum_prod = HP_W'({humidity_raw[ptc_pkg::HRAW_W-1:2], 2'b00})
                   * HP_W'(ptc_pkg::HUM_SCALE);
   assign s1_hum_in = $signed({1'b0, hum_prod[HP_W-1:16]}) + HUM_W'(ptc_pkg::HUM_OFFSET);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s1_dt_ff  <= s1_dt_in;
         s1_d1_ff  <= s1_d1_in;
         s1_hum_ff <= s1_hum_in;
      end
   end

   // ---------------- stage 2: dT times C3, C4, C6
   logic signed [MUL_W-1:0]  s2_p3_ff, s2_p3_in;
   logic signed [MUL_W-1:0]  s2_p4_ff, s2_p4_in;
   logic signed [MUL_W-1:0]  s2_p6_ff, s2_p6_in;
   logic [ADC_BITS-1:0]      s2_d1_ff;
   logic signed [HUM_W-1:0]  s2_hum_ff;

   assign s2_p3_in = ptc_pkg::mul_dt(s1_dt_ff, coef.c3);
   assign s2_p4_in = ptc_pkg::mul_dt(s1_dt_ff, coef.c4);
   assign s2_p6_in = ptc_pkg::mul_dt(s1_dt_ff, coef.c6);

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s2_p3_ff  <= s2_p3_in;
         s2_p4_ff  <= s2_p4_in;
         s2_p6_ff  <= s2_p6_in;
         s2_d1_ff  <= s1_d1_ff;
         s2_hum_ff <= s1_hum_ff;
      end
   end

   // ---------------- stage 3: OFF, SENS, saturated TEMP
   logic signed [MUL_W-1:0]  p3_sh, p4_sh, p6_sh;
   logic signed [TSUM_W-1:0] t_sum;
   logic signed [OFF_W-1:0]  s3_off_ff,  s3_off_in;
   logic signed [SENS_W-1:0] s3_sens_ff, s3_sens_in;
   logic signed [TEMP_W-1:0] s3_temp_ff, s3_temp_in;
   logic [ADC_BITS-1:0]      s3_d1_ff;
   logic signed [HUM_W-1:0]  s3_hum_ff;

   assign p3_sh = s2_p3_ff >>> 7;
   assign p4_sh = s2_p4_ff >>> 6;
   assign p6_sh = s2_p6_ff >>> 23;

   assign s3_off_in  = $signed({{(OFF_W-COEF_W-17){1'b0}}, coef.c2, 17'd0})
                     + $signed(p4_sh[OFF_W-1:0]);
   assign s3_sens_in = $signed({{(SENS_W-COEF_W-16){1'b0}}, coef.c1, 16'd0})
                     + $signed(p3_sh[SENS_W-1:0]);
   assign t_sum      = $signed(p6_sh[TSUM_W-1:0]) + TSUM_W'(ptc_pkg::TEMP_BASE);

   always_comb begin
      if (t_sum > ptc_pkg::TEMP_MAX) begin
         s3_temp_in = TEMP_W'(ptc_pkg::TEMP_MAX);
      end else if (t_sum < ptc_pkg::TEMP_MIN) begin
         s3_temp_in = TEMP_W'(ptc_pkg::TEMP_MIN);
      end else begin
         s3_temp_in = t_sum[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_temp_ff <= s3_temp_in;
         s3_d1_ff   <= s2_d1_ff;
         s3_hum_ff  <= s2_hum_ff;
      end
   end

   // ---------------- stage 4: split D1*SENS, |TEMP| times 1/100 reciprocal
   logic [PLO_W-1:0]         s4_plo_ff, s4_plo_in;
   logic signed [PHI_W-1:0]  s4_phi_ff, s4_phi_in;
   logic [TEMP_W-1:0]        t_abs;
   logic [QP_W-1:0]          s4_qp_ff,  s4_qp_in;
   logic                     s4_tneg_ff;
   logic signed [OFF_W-1:0]  s4_off_ff;
   logic signed [TEMP_W-1:0] s4_temp_ff;
   logic signed [HUM_W-1:0]  s4_hum_ff;

   assign s4_plo_in = PLO_W'(s3_d1_ff) * PLO_W'(s3_sens_ff[SLO_W-1:0]);
   assign s4_phi_in = $signed({{(PHI_W-ADC_BITS){1'b0}}, s3_d1_ff})
                    * $signed({{(PHI_W-SHI_W){s3_sens_ff[SENS_W-1]}},
                               s3_sens_ff[SENS_W-1:SLO_W]});
   assign t_abs     = s3_temp_ff[TEMP_W-1] ? (~s3_temp_ff + 1'b1) : s3_temp_ff;
   assign s4_qp_in  = QP_W'(t_abs) * QP_W'(ptc_pkg::DEG_RECIP);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s4_plo_ff  <= s4_plo_in;
         s4_phi_ff  <= s4_phi_in;
         s4_qp_ff   <= s4_qp_in;
         s4_tneg_ff <= s3_temp_ff[TEMP_W-1];
         s4_off_ff  <= s3_off_ff;
         s4_temp_ff <= s3_temp_ff;
         s4_hum_ff  <= s3_hum_ff;
      end
   end

   // ---------------- stage 5: recombine product, scale, whole degrees
   logic signed [FULL_W-1:0] full_prod;
   logic signed [FULL_W-1:0] full_sh;
   logic [DEG_W-1:0]         deg_mag;
   logic signed [PS_W-1:0]   s5_ps_ff,  s5_ps_in;
   logic signed [DEG_W-1:0]  s5_deg_ff, s5_deg_in;
   logic signed [OFF_W-1:0]  s5_off_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff;
   logic signed [HUM_W-1:0]  s5_hum_ff;

   assign full_prod = $signed({s4_phi_ff, {SLO_W{1'b0}}})
                    + $signed({{(FULL_W-PLO_W){1'b0}}, s4_plo_ff});
   assign full_sh   = full_prod >>> 21;
   assign s5_ps_in  = full_sh[PS_W-1:0];
   assign deg_mag   = {1'b0, s4_qp_ff[ptc_pkg::DEG_SH+DEG_W-2:ptc_pkg::DEG_SH]};
   // truncate toward zero: negate the magnitude quotient
   assign s5_deg_in = s4_tneg_ff ? -$signed(deg_mag) : $signed(deg_mag);

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s5_ps_ff   <= s5_ps_in;
         s5_deg_ff  <= s5_deg_in;
         s5_off_ff  <= s4_off_ff;
         s5_temp_ff <= s4_temp_ff;
         s5_hum_ff  <= s4_hum_ff;
      end
   end

   // ---------------- stage 6: pressure and adjusted humidity, saturate
   logic signed [DIFF_W-1:0] p_diff;
   logic signed [DIFF_W-1:0] p_sh;
   logic signed [D20_W-1:0]  deg_rel;
   logic signed [ADJ_W-1:0]  hum_adj;
   logic signed [ADJ_W-1:0]  hum_sum;
   logic signed [TEMP_W-1:0] s6_temp_ff;
   logic signed [PRES_W-1:0] s6_pres_ff, s6_pres_in;
   logic signed [HUM_W-1:0]  s6_hum_ff;
   logic signed [HC_W-1:0]   s6_hcomp_ff, s6_hcomp_in;

   assign p_diff  = $signed({{(DIFF_W-PS_W){s5_ps_ff[PS_W-1]}}, s5_ps_ff})
                  - $signed({{(DIFF_W-OFF_W){s5_off_ff[OFF_W-1]}}, s5_off_ff});
   assign p_sh    = p_diff >>> 15;

   always_comb begin
      if (p_sh > ptc_pkg::PRES_MAX) begin
         s6_pres_in = PRES_W'(ptc_pkg::PRES_MAX);
      end else if (p_sh < ptc_pkg::PRES_MIN) begin
         s6_pres_in = PRES_W'(ptc_pkg::PRES_MIN);
      end else begin
         s6_pres_in = p_sh[PRES_W-1:0];
      end
   end

   assign deg_rel = D20_W'(ptc_pkg::HUM_REF_DEG) - $signed({s5_deg_ff[DEG_W-1], s5_deg_ff});
   assign hum_adj = $signed({{(ADJ_W-D20_W){deg_rel[D20_W-1]}}, deg_rel})
                  * ADJ_W'(ptc_pkg::HUM_SLOPE);
   assign hum_sum = hum_adj + $signed({{(ADJ_W-HUM_W){s5_hum_ff[HUM_W-1]}}, s5_hum_ff});

   always_comb begin
      if (hum_sum > ptc_pkg::HCOMP_MAX) begin
         s6_hcomp_in = HC_W'(ptc_pkg::HCOMP_MAX);
      end else if (hum_sum < ptc_pkg::HCOMP_MIN) begin
         s6_hcomp_in = HC_W'(ptc_pkg::HCOMP_MIN);
      end else begin
         s6_hcomp_in = hum_sum[HC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         s6_temp_ff  <= s5_temp_ff;
         s6_pres_ff  <= s6_pres_in;
         s6_hum_ff   <= s5_hum_ff;
         s6_hcomp_ff <= s6_hcomp_in;
      end
   end

   assign temperature_centi    = s6_temp_ff;
   assign pressure_centi_mbar  = s6_pres_ff;
   assign humidity_plain_centi = s6_hum_ff;
   assign humidity_comp_centi  = s6_hcomp_ff;

endmodule

// ===== rtl/pressure_temp_humidity_compensation.sv =====
// Barometric sensor compensation: raw D1/D2/humidity beats in, calibrated beats out.
//
// req_chan carries one raw pressure conversion, one raw temperature conversion and
// one raw humidity word per beat; rsp_chan returns temperature (0.01 degC),
// pressure (0.01 mbar), plain humidity and temperature-adjusted humidity (0.01 %).
// Only the low ADC_BITS bits of the raw conversions are used.
// Coefficients C1..C6 are loaded through csr_we/csr_index/csr_wdata (index 0..5);
// other indexes are ignored. Load them only while no beat is in flight.
// A request beat passes through the six register stages (dT, coefficient products,
// OFF/SENS/TEMP, split D1*SENS multiply, recombine, final subtract and saturate),
// and rsp_chan.valid rises once the last stage holds it.
// Throughput: one beat per cycle while rsp_chan is not stalled.
// When rsp_chan stalls, the filled stages hold their beats and empty stages keep
// loading, so req_chan.ready stays high until every stage is occupied.
// Reset clears all stage valid bits and the coefficients to zero; rsp_chan.valid
// is low the cycle after reset.
module pressure_temp_humidity_compensation #(
   parameter int ADC_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   ptc_req_if.sink                             req_chan,
   ptc_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]          csr_wdata
);

   ptc_pkg::coef_type     coef;
   ptc_pkg::pipe_ctl_type ctl;

   ptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   ptc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   ptc_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_dp (
      .clock                (clock),
      .ctl                  (ctl),
      .coef                 (coef),
      .pressure_raw         (req_chan.pressure_raw),
      .temperature_raw      (req_chan.temperature_raw),
      .humidity_raw         (req_chan.humidity_raw),
      .temperature_centi    (rsp_chan.temperature_centi),
      .pressure_centi_mbar  (rsp_chan.pressure_centi_mbar),
      .humidity_plain_centi (rsp_chan.humidity_plain_centi),
      .humidity_comp_centi  (rsp_chan.humidity_comp_centi)
   );

endmodule

// ===== rtl/ptc_checker.sv =====
// Port-level checks on the compensation block, bound to its top level.
module ptc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centi,
   input logic signed [ptc_pkg::PRES_W-1:0]  pressure_centi_mbar,
   input logic signed [ptc_pkg::HUM_W-1:0]   humidity_plain_centi,
   input logic signed [ptc_pkg::HCOMP_W-1:0] humidity_comp_centi
);

   // a stalled response beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a stalled response beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(temperature_centi) && $stable(pressure_centi_mbar)
         && $stable(humidity_plain_centi) && $stable(humidity_comp_centi))
      else $error("response payload changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // the humidity scaling cannot leave its span
   a_hum_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> humidity_plain_centi >= -600 && humidity_plain_centi <= 11900)
      else $error("plain humidity out of span");

   // at exactly 20 degC the adjustment is zero
   a_hum_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && temperature_centi == 2000 |->
         humidity_comp_centi == {humidity_plain_centi[ptc_pkg::HUM_W-1], humidity_plain_centi})
      else $error("humidity adjusted at reference temperature");

endmodule

bind pressure_temp_humidity_compensation ptc_checker u_ptc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .temperature_centi    (rsp_chan.temperature_centi),
   .pressure_centi_mbar  (rsp_chan.pressure_centi_mbar),
   .humidity_plain_centi (rsp_chan.humidity_plain_centi),
   .humidity_comp_centi  (rsp_chan.humidity_comp_centi)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the sensor compensation block: corner and random beats.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptc_pkg::*;

   localparam int ADC_BITS    = 24;
   localparam int QUIET_LIMIT = 20000;
   localparam int BATCH       = 100;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;
   localparam logic [RAW_W-1:0]     RAW_MAX     = '1;
   localparam logic [COEF_W-1:0]    COEF_MAX    = '1;
   localparam logic [HRAW_W-1:0]    HUM_STATUS_MASK = 16'hFFFC;

   // scaling of the compensated outputs, all in hundredths
   localparam longint T_OFFSET      = 2000;
   localparam longint CENTI_PER_DEG = 100;
   localparam longint H_OFFSET      = -600;
   localparam longint H_SPAN        = 12500;
   localparam longint H_SLOPE       = 18;
   localparam longint H_REF_DEG     = 20;

   typedef struct packed {
      logic [RAW_W-1:0]  pressure_raw;
      logic [RAW_W-1:0]  temperature_raw;
      logic [HRAW_W-1:0] humidity_raw;
   } raw_beat_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  temperature_centi;
      logic signed [PRES_W-1:0]  pressure_centi_mbar;
      logic signed [HUM_W-1:0]   humidity_plain_centi;
      logic signed [HCOMP_W-1:0] humidity_comp_centi;
   } reading_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   ptc_req_if req_chan ();
   ptc_rsp_if rsp_chan ();

   coef_type    coefs;
   reading_type pending_readings[$];
   reading_type oldest;
   int          send_gap_pct     = 0;
   int          rsp_stall_pct    = 0;
   int          beats_sent       = 0;
   int          readings_checked = 0;
   int          mismatches       = 0;
   int          quiet_cycles     = 0;

   pressure_temp_humidity_compensation #(.ADC_BITS(ADC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Exact integer compensation; >>> on longint is a floor shift.
   function automatic reading_type compensate(raw_beat_type beat, coef_type k);
      longint adc_mask, d1, d2, hraw, dt, off, sens, temp, pres, hplain, degrees, hcomp;
      reading_type r;
      adc_mask = (longint'(1) <<< ADC_BITS) - 1;
      d1   = longint'(beat.pressure_raw) & adc_mask;
      d2   = longint'(beat.temperature_raw) & adc_mask;
      hraw = longint'(beat.humidity_raw & HUM_STATUS_MASK);
      dt   = d2 - longint'(k.c5) * 256;
      off  = longint'(k.c2) * 131072 + ((dt * longint'(k.c4)) >>> 6);
      sens = longint'(k.c1) * 65536 + ((dt * longint'(k.c3)) >>> 7);
      temp = clip(T_OFFSET + ((dt * longint'(k.c6)) >>> 23), TEMP_MIN, TEMP_MAX);
      pres = clip((((d1 * sens) >>> 21) - off) >>> 15, PRES_MIN, PRES_MAX);
      hplain = H_OFFSET + ((H_SPAN * hraw) >>> 16);
      // whole degrees truncate toward zero, so -150 gives -1
      degrees = temp / CENTI_PER_DEG;
      hcomp = clip(hplain + H_SLOPE * (H_REF_DEG - degrees), HCOMP_MIN, HCOMP_MAX);
      r.temperature_centi    = temp[TEMP_W-1:0];
      r.pressure_centi_mbar  = pres[PRES_W-1:0];
      r.humidity_plain_centi = hplain[HUM_W-1:0];
      r.humidity_comp_centi  = hcomp[HCOMP_W-1:0];
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(7))
         0: return '0;
         1: return COEF_MAX;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic check_field(string field, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Compare each accepted result beat and watch for a stuck handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_readings.size() == 0) begin
               $display("%0t: unexpected result beat, temperature_centi %0d", $time,
                        rsp_chan.temperature_centi);
               mismatches++;
            end else begin
               oldest = pending_readings.pop_front();
               check_field("temperature_centi", oldest.temperature_centi,
                           rsp_chan.temperature_centi);
               check_field("pressure_centi_mbar", oldest.pressure_centi_mbar,
                           rsp_chan.pressure_centi_mbar);
               check_field("humidity_plain_centi", oldest.humidity_plain_centi,
                           rsp_chan.humidity_plain_centi);
               check_field("humidity_comp_centi", oldest.humidity_comp_centi,
                           rsp_chan.humidity_comp_centi);
               readings_checked++;
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb failed");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Drop valid and hold until every expected reading has come back.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_C1: coefs.c1 = value;
         REG_C2: coefs.c2 = value;
         REG_C3: coefs.c3 = value;
         REG_C4: coefs.c4 = value;
         REG_C5: coefs.c5 = value;
         REG_C6: coefs.c6 = value;
         default: ;
      endcase
   endtask

   task automatic load_coefs(logic [COEF_W-1:0] c1, logic [COEF_W-1:0] c2,
                             logic [COEF_W-1:0] c3, logic [COEF_W-1:0] c4,
                             logic [COEF_W-1:0] c5, logic [COEF_W-1:0] c6);
      wait_for_results();
      write_reg(REG_C1, c1);
      write_reg(REG_C2, c2);
      write_reg(REG_C3, c3);
      write_reg(REG_C4, c4);
      write_reg(REG_C5, c5);
      write_reg(REG_C6, c6);
   endtask

   task automatic send_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2,
                               logic [HRAW_W-1:0] hum);
      raw_beat_type beat;
      beat = {d1, d2, hum};
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.pressure_raw    <= d1;
      req_chan.temperature_raw <= d2;
      req_chan.humidity_raw    <= hum;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_readings.push_back(compensate(beat, coefs));
      beats_sent++;
   endtask

   // Temperatures near the reference point half the time, plus full-range and extreme raw values.
   task automatic send_random_reading();
      logic [RAW_W-1:0] d1;
      logic [RAW_W-1:0] d2;
      longint           near;
      int               pick;
      pick = $urandom_range(9);
      near = longint'(coefs.c5) * 256 + longint'($urandom_range(131071)) - 65536;
      near = clip(near, 0, longint'(RAW_MAX));
      if (pick < 5)
         d2 = near[RAW_W-1:0];
      else if (pick < 9)
         d2 = RAW_W'($urandom);
      else
         d2 = $urandom_range(1) ? RAW_MAX : '0;
      case ($urandom_range(15))
         0: d1 = '0;
         1: d1 = RAW_MAX;
         default: d1 = RAW_W'($urandom);
      endcase
      send_reading(d1, d2, HRAW_W'($urandom));
   endtask

   task automatic test_reset_coefficients();
      send_reading('0, '0, '0);
      send_reading(RAW_MAX, RAW_MAX, 16'hFFFF);
   endtask

   task automatic test_typical_calibration();
      load_coefs(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
      send_reading(24'd6465444, 24'd8077636, 16'h6ABC);
      // temperature exactly at the reference point
      send_reading(24'd6465444, 24'd8077568, 16'h0003);
      send_reading(24'd6465444, 24'd8077636, 16'hFFFF);
      send_reading(24'd6465444, 24'd8077636, 16'hFFFC);
      send_reading(24'd4000000, 24'd7000000, 16'h0000);
   endtask

   task automatic test_saturation();
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_reading(RAW_MAX, RAW_MAX, 16'hFFFF);
      send_reading(RAW_MAX, RAW_MAX, 16'h0000);
      // deep cold pushes the adjusted humidity past its top
      send_reading('0, '0, 16'hFFFF);
      load_coefs('0, '0, COEF_MAX, '0, COEF_MAX, '0);
      send_reading(RAW_MAX, '0, 16'h8000);
      send_reading(RAW_MAX, RAW_MAX, 16'h7FFF);
   endtask

   task automatic test_negative_temperature();
      // C6 = 2^13 makes TEMP = 2000 + dT/1024, so D2 picks exact temperatures
      load_coefs(16'd46372, 16'd43981, 16'd29059, 16'd27842, COEF_MAX, 16'h2000);
      send_reading(24'd6465444, 24'd14575360, 16'h5555);   // -1.50 degC
      send_reading(24'd6465444, 24'd14626560, 16'hAAAA);   // -1.00 degC
      send_reading(24'd6465444, 24'd14627584, 16'h5555);   // -0.99 degC
      send_reading(24'd6465444, 24'd14727936, 16'hAAAA);   // -0.01 degC
   endtask

   task automatic test_spare_register_index();
      load_coefs(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
      write_reg(REG_SPARE_A, 16'h5A5A);
      write_reg(REG_SPARE_B, COEF_MAX);
      send_reading(24'd6465444, 24'd8077636, 16'h6ABC);
      send_reading(24'd9000000, 24'd9000000, 16'h1234);
   endtask

   task automatic run_random_phase(int gap_pct, int stall_pct, int items);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < items; n++) begin
         if (n % BATCH == 0)
            load_coefs(pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), pick_coef(), pick_coef());
         else if ($urandom_range(59) == 0)
            wait_for_results();
         send_random_reading();
      end
   endtask

   initial begin
      req_chan.valid           = 1'b0;
      req_chan.pressure_raw    = '0;
      req_chan.temperature_raw = '0;
      req_chan.humidity_raw    = '0;
      rsp_chan.ready           = 1'b0;
      csr_we                   = 1'b0;
      csr_index                = '0;
      csr_wdata                = '0;
      coefs                    = '0;
      rsp_stall_pct            = 30;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_coefficients();
      test_typical_calibration();
      test_saturation();
      test_negative_temperature();
      test_spare_register_index();
      run_random_phase(6, 55, 300);
      run_random_phase(55, 6, 300);
      run_random_phase(0, 0, 300);

      wait_for_results();
      repeat (2 * STAGES) @(posedge clock);

      if (pending_readings.size() != 0)
         $display("%0t: %0d expected readings never arrived", $time, pending_readings.size());
      $display("Sent %0d raw beats: saturation corners, cold readings, spare indexes,", beats_sent);
      $display("then random calibrations under three pacing mixes; %0d readings checked.",
               readings_checked);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
